FILE: rtl/sdog_pkg.sv
// Shared constants for the degenerate-octree point indexer: field widths and cell-type codes.
`timescale 1ns / 1ps
`default_nettype none

package sdog_pkg;

   // Fixed field widths of the request and response payloads
   localparam int COORD_IN_W = 33;
   localparam int LEVELS_W   = 5;
   localparam int INDEX_W    = 61;

   // Cell types
   localparam int CTYPE_W = 2;
   localparam logic [CTYPE_W-1:0] CTYPE_SG = 2'd0;
   localparam logic [CTYPE_W-1:0] CTYPE_LG = 2'd1;
   localparam logic [CTYPE_W-1:0] CTYPE_NG = 2'd2;

   // Child code that keeps a sphere-grid cell a sphere-grid cell
   localparam logic [2:0] CODE_SG_INNER = 3'b100;

endpackage

`default_nettype wire

FILE: rtl/sdog_point_to_cell_index.sv
// Top level: pipelined point-to-cell indexer, one register stage per refinement level.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Payload
// req_      in   req_valid/req_ready   radius, latitude, longitude (33b), levels (5b)
// rsp_      out  rsp_valid/rsp_ready   cell_index (61b)
//
// Takes one request per cycle unless a response waits; each response passes the
// input register, one stage per level and the output register.
// Throughput is set by nothing but back-pressure: a stalled response freezes
// every stage at once, so req_ready follows rsp_ready while a response waits.
// Synchronous active-high reset clears the valid bits only; payload flops are
// not reset.

module sdog_point_to_cell_index #(
   parameter int COORD_BITS = 32,
   parameter int MAX_LEVEL  = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [sdog_pkg::COORD_IN_W-1:0]   req_radius,
   input  wire logic [sdog_pkg::COORD_IN_W-1:0]   req_latitude,
   input  wire logic [sdog_pkg::COORD_IN_W-1:0]   req_longitude,
   input  wire logic [sdog_pkg::LEVELS_W-1:0]     req_levels,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [sdog_pkg::INDEX_W-1:0]      rsp_cell_index
);

   // Masked coordinate width, doubled width (midpoints stay exact), index width
   localparam int CW        = COORD_BITS + 1;
   localparam int DW        = COORD_BITS + 2;
   localparam int IN_KEEP   = (CW < sdog_pkg::COORD_IN_W) ? CW : sdog_pkg::COORD_IN_W;
   localparam int IDX_W     = 3 * MAX_LEVEL + 1;
   localparam int LVL_W     = sdog_pkg::LEVELS_W;
   localparam int IDX_OUT_W = sdog_pkg::INDEX_W;
   localparam int NSTAGE    = MAX_LEVEL + 1;   // input register plus one per level

   typedef struct packed {
      logic [LVL_W-1:0]             levels;
      logic [DW-1:0]                r2;
      logic [DW-1:0]                l2;
      logic [DW-1:0]                g2;
      logic [DW-1:0]                rlo;
      logic [DW-1:0]                llo;
      logic [DW-1:0]                glo;
      logic [DW-1:0]                lstep;   // one-hot half-width of the latitude interval
      logic [DW-1:0]                gstep;   // one-hot half-width of the longitude interval
      logic [sdog_pkg::CTYPE_W-1:0] ctype;
      logic [IDX_W-1:0]             idx;
   } stage_type;

   stage_type stage_ff [0:NSTAGE-1];
   stage_type stage_in [0:NSTAGE-1];
   logic      valid_ff [0:NSTAGE-1];

   logic                 out_valid_ff;
   logic [IDX_OUT_W-1:0] out_index_ff;
   logic                 advance;

   // Whole pipeline moves together; it only halts while a response waits
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_cell_index = out_index_ff;

   // Input stage: mask to COORD_BITS+1 bits, double, saturate the level count
   always_comb begin
      stage_in[0].r2     = DW'(req_radius[IN_KEEP-1:0]) << 1;
      stage_in[0].l2     = DW'(req_latitude[IN_KEEP-1:0]) << 1;
      stage_in[0].g2     = DW'(req_longitude[IN_KEEP-1:0]) << 1;
      stage_in[0].levels = (req_levels > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : req_levels;
      stage_in[0].rlo    = '0;
      stage_in[0].llo    = '0;
      stage_in[0].glo    = '0;
      stage_in[0].lstep  = DW'(1) << COORD_BITS;
      stage_in[0].gstep  = DW'(1) << COORD_BITS;
      stage_in[0].ctype  = sdog_pkg::CTYPE_SG;
      stage_in[0].idx    = IDX_W'(1);
   end

   // One refinement level per stage. Bounds are sums of larger powers of two,
   // so lo | step is the midpoint without an adder.
   for (genvar gi = 0; gi < MAX_LEVEL; gi++) begin : g_level
      localparam logic [DW-1:0] RSTEP = DW'(1) << (COORD_BITS - gi);

      stage_type cur;
      logic [DW-1:0] rm, lm, gm;
      logic          active, rad_hi, lat_lo, lng_lo, sg_stay, g_split;
      logic [2:0]    code;

      assign cur = stage_ff[gi];

      always_comb begin
         rm      = cur.rlo | RSTEP;
         lm      = cur.llo | cur.lstep;
         gm      = cur.glo | cur.gstep;
         active  = cur.levels > LVL_W'(gi);
         rad_hi  = cur.r2 > rm;
         lat_lo  = cur.l2 < lm;
         lng_lo  = cur.g2 < gm;
         sg_stay = (cur.ctype == sdog_pkg::CTYPE_SG) && !rad_hi;
         g_split = lat_lo || (cur.ctype == sdog_pkg::CTYPE_NG);
         code    = sdog_pkg::CODE_SG_INNER;

         stage_in[gi+1] = cur;
         if (active) begin
            if (rad_hi) begin
               stage_in[gi+1].rlo = rm;
            end
            if (!sg_stay) begin
               code = {!rad_hi, !lat_lo, g_split && !lng_lo};
               stage_in[gi+1].lstep = cur.lstep[0] ? cur.lstep : (cur.lstep >> 1);
               if (!lat_lo) begin
                  stage_in[gi+1].llo = lm;
               end
               if (g_split) begin
                  stage_in[gi+1].gstep = cur.gstep[0] ? cur.gstep : (cur.gstep >> 1);
                  if (!lng_lo) begin
                     stage_in[gi+1].glo = gm;
                  end
               end
               if (lat_lo) begin
                  stage_in[gi+1].ctype = sdog_pkg::CTYPE_NG;
               end else if (cur.ctype == sdog_pkg::CTYPE_SG) begin
                  stage_in[gi+1].ctype = sdog_pkg::CTYPE_LG;
               end
            end
            stage_in[gi+1].idx = {cur.idx[IDX_W-4:0], code};
         end
      end
   end

   // Stage registers; valid bits travel alongside
   for (genvar gs = 0; gs < NSTAGE; gs++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[gs] <= stage_in[gs];
         end
      end

      if (gs == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gs] <= 1'b0;
            end else if (advance) begin
               valid_ff[gs] <= req_valid;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gs] <= 1'b0;
            end else if (advance) begin
               valid_ff[gs] <= valid_ff[gs-1];
            end
         end
      end
   end

   // Output register: index cut or zero-extended to the response width
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff <= IDX_OUT_W'(stage_ff[NSTAGE-1].idx);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sdog_checker.sv
// Port-level checker for the point indexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdog_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [sdog_pkg::INDEX_W-1:0] rsp_cell_index
);

   // Held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_index))
      else $error("response changed while stalled");

   // Pipeline only refuses requests while a response is stuck
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a stalled response");

   // A stuck response freezes the whole pipe
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the pipeline is frozen");

   // Reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sdog_point_to_cell_index sdog_checker u_sdog_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_index (rsp_cell_index)
);

`default_nettype wire

FILE: tb/tb_sdog_point_to_cell_index.sv
// Self-checking testbench for the pipelined degenerate-octree point-to-cell indexer.
`timescale 1ns / 1ps

module tb_sdog_point_to_cell_index;

   localparam int CLK_PERIOD = 10;
   localparam int COORD_BITS = 32;
   localparam int MAX_LEVEL  = 20;
   localparam int COORD_IN_W = sdog_pkg::COORD_IN_W;
   localparam int LEVELS_W   = sdog_pkg::LEVELS_W;
   localparam int INDEX_W    = sdog_pkg::INDEX_W;
   localparam int CTYPE_W    = sdog_pkg::CTYPE_W;
   // Pipeline depth per the block's header: input reg, one stage per level, output reg
   localparam int PIPE_DEPTH = MAX_LEVEL + 2;
   localparam int HOLD_CYCLES = 4 * PIPE_DEPTH;

   // Coordinate landmarks (undoubled): half scale, full scale, all 33 bits set
   localparam logic [COORD_IN_W-1:0] C_HALF = 33'h0_8000_0000;
   localparam logic [COORD_IN_W-1:0] C_FULL = 33'h1_0000_0000;
   localparam logic [COORD_IN_W-1:0] C_TOP  = 33'h1_FFFF_FFFF;

   // Child-code bits: radius at or below mid, latitude at or above mid,
   // longitude at or above mid
   localparam logic [2:0] BIT_RAD_LOW  = 3'b100;
   localparam logic [2:0] BIT_LAT_HIGH = 3'b010;
   localparam logic [2:0] BIT_LNG_HIGH = 3'b001;

   // Expected-index store plus its own predictor of the descent
   class cell_index_board_type;
      logic [INDEX_W-1:0] expected_q[$];
      int unsigned mismatch_count;
      int unsigned checked_count;
      int unsigned request_count;
      int unsigned saturated_count;

      function new();
         mismatch_count  = 0;
         checked_count   = 0;
         request_count   = 0;
         saturated_count = 0;
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      // Doubled midpoint of a dimension whose doubled lower bound is lo2
      function logic [63:0] split_point(logic [63:0] lo2, int unsigned depth);
         int e;
         e = COORD_BITS - int'(depth);
         if (e < 0)
            e = 0;
         return lo2 + (64'd1 << e);
      endfunction

      function logic [INDEX_W-1:0] predict_cell_index(logic [COORD_IN_W-1:0] rad,
                                                      logic [COORD_IN_W-1:0] lat,
                                                      logic [COORD_IN_W-1:0] lng,
                                                      logic [LEVELS_W-1:0] lev);
         logic [63:0] r2, l2, g2, rlo, llo, glo, rm, lm, gm, idx;
         logic [COORD_BITS:0] cmask;
         int unsigned rd, ld, gd, n;
         logic [CTYPE_W-1:0] ctype;
         logic [2:0] code;
         cmask = '1;
         r2 = {31'd0, rad & cmask} << 1;
         l2 = {31'd0, lat & cmask} << 1;
         g2 = {31'd0, lng & cmask} << 1;
         rlo = '0; llo = '0; glo = '0;
         rd = 0; ld = 0; gd = 0;
         ctype = sdog_pkg::CTYPE_SG;
         idx = 64'd1;
         n = (lev > MAX_LEVEL) ? MAX_LEVEL : lev;
         for (int i = 0; i < n; i++) begin
            rm = split_point(rlo, rd);
            lm = split_point(llo, ld);
            gm = split_point(glo, gd);
            code = '0;
            if (ctype == sdog_pkg::CTYPE_SG && !(r2 > rm)) begin
               // inner sphere-grid child: only the radius is split
               code = sdog_pkg::CODE_SG_INNER;
               rd++;
            end else begin
               if (r2 > rm)
                  rlo = rm;
               else
                  code |= BIT_RAD_LOW;
               rd++;
               ld++;
               if (l2 < lm) begin
                  ctype = sdog_pkg::CTYPE_NG;
                  gd++;
                  if (!(g2 < gm)) begin
                     code |= BIT_LNG_HIGH;
                     glo = gm;
                  end
               end else begin
                  code |= BIT_LAT_HIGH;
                  llo = lm;
                  if (ctype == sdog_pkg::CTYPE_SG) begin
                     ctype = sdog_pkg::CTYPE_LG;
                  end else if (ctype == sdog_pkg::CTYPE_NG) begin
                     gd++;
                     if (!(g2 < gm)) begin
                        code |= BIT_LNG_HIGH;
                        glo = gm;
                     end
                  end
               end
            end
            idx = (idx << 3) | {61'd0, code};
         end
         return idx[INDEX_W-1:0];
      endfunction

      task note_request(logic [COORD_IN_W-1:0] rad, logic [COORD_IN_W-1:0] lat,
                        logic [COORD_IN_W-1:0] lng, logic [LEVELS_W-1:0] lev);
         request_count++;
         if (lev > MAX_LEVEL)
            saturated_count++;
         expected_q.push_back(predict_cell_index(rad, lat, lng, lev));
      endtask

      task check_response(logic [INDEX_W-1:0] got);
         logic [INDEX_W-1:0] want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing outstanding", got));
         end else begin
            want = expected_q.pop_front();
            checked_count++;
            if (got !== want)
               report_mismatch($sformatf("cell_index got %h want %h", got, want));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [COORD_IN_W-1:0] req_radius;
   logic [COORD_IN_W-1:0] req_latitude;
   logic [COORD_IN_W-1:0] req_longitude;
   logic [LEVELS_W-1:0]   req_levels;
   logic rsp_valid;
   logic rsp_ready;
   logic [INDEX_W-1:0] rsp_cell_index;

   cell_index_board_type board = new();

   // Knobs shared between the stimulus thread and the response sink
   bit gaps_on;
   bit stalls_on;
   bit hold_off_pending;
   int unsigned backpressure_cycles;

   always #(CLK_PERIOD / 2) clock = ~clock;

   sdog_point_to_cell_index #(
      .COORD_BITS (COORD_BITS),
      .MAX_LEVEL  (MAX_LEVEL)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_radius     (req_radius),
      .req_latitude   (req_latitude),
      .req_longitude  (req_longitude),
      .req_levels     (req_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_index (rsp_cell_index)
   );

   // Monitor: everything is sampled at the edge, before this edge's drives land.
   // Requests are noted before responses are checked, so the order is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_radius, req_latitude, req_longitude, req_levels);
         if (req_valid && !req_ready)
            backpressure_cycles++;
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_cell_index);
      end
   end

   // Response sink: random stall bursts, or one long hold-off when asked.
   // The hold-off is timed here so the sender keeps offering requests meanwhile.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until taken. Called at a rising edge;
   // returns at the edge where the request was accepted.
   task automatic send_point(logic [COORD_IN_W-1:0] rad, logic [COORD_IN_W-1:0] lat,
                             logic [COORD_IN_W-1:0] lng, logic [LEVELS_W-1:0] lev);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_radius    <= rad;
      req_latitude  <= lat;
      req_longitude <= lng;
      req_levels    <= lev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and sit until every outstanding response is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Mostly in-range values, a good share sitting on or next to a split
   // boundary at some depth, and a few at or above full scale
   function automatic logic [COORD_IN_W-1:0] rand_coord();
      int unsigned pick, d;
      logic [COORD_IN_W-1:0] v;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         v = {1'b0, $urandom()};
      end else if (pick < 9) begin
         d = $urandom_range(1, MAX_LEVEL);
         v = ({1'b0, $urandom()} >> (COORD_BITS - d)) << (COORD_BITS - d);
         v = v + COORD_IN_W'($urandom_range(0, 2)) - COORD_IN_W'(1);
      end else if ($urandom_range(0, 3) == 0) begin
         v = C_FULL;
      end else begin
         v = {1'b1, $urandom()};
      end
      return v;
   endfunction

   function automatic logic [LEVELS_W-1:0] rand_levels();
      if ($urandom_range(0, 9) < 8)
         return LEVELS_W'($urandom_range(0, MAX_LEVEL));
      return LEVELS_W'($urandom_range(MAX_LEVEL + 1, 31));
   endfunction

   task automatic send_random(int unsigned count);
      repeat (count) send_point(rand_coord(), rand_coord(), rand_coord(), rand_levels());
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_radius    <= '0;
      req_latitude  <= '0;
      req_longitude <= '0;
      req_levels    <= '0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      hold_off_pending = 1'b0;
      backpressure_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: level-count extremes and saturation
      send_point('0, '0, '0, 5'd0);                       // zero levels gives bare leading 1
      send_point('0, '0, '0, 5'd1);
      send_point('0, '0, '0, 5'd20);                      // stays SG all the way down
      send_point(C_FULL, C_FULL, C_FULL, 5'd20);
      send_point(C_TOP, C_TOP, C_TOP, 5'd31);             // above full scale, levels saturate
      send_point(C_TOP, '0, C_TOP, 5'd21);
      send_point(33'h0_AAAA_AAAA, 33'h1_5555_5555, 33'h0_AAAA_AAAA, 5'd16);
      send_point(33'h1_5555_5555, 33'h0_AAAA_AAAA, 33'h1_5555_5555, 5'd8);
      // Radius exactly on the midpoint counts as inner
      send_point(C_HALF, C_HALF, C_HALF, 5'd1);
      send_point(C_HALF + 1, C_HALF, '0, 5'd1);           // SG to LG, latitude on mid
      send_point(C_HALF + 1, C_HALF - 1, C_HALF, 5'd1);   // SG to NG, longitude on mid
      send_point(C_HALF + 1, C_HALF - 1, C_HALF - 1, 5'd1);
      send_point(C_HALF + 1, C_HALF - 1, C_HALF - 1, 5'd2);
      // SG to LG, then LG to NG at the next latitude split
      send_point(33'h0_C000_0000, 33'h0_A000_0000, 33'h0_9000_0000, 5'd5);
      send_point(33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF, '0, 5'd20);   // LG stays LG
      send_point(33'h0_0000_0001, '0, 33'h0_AAAA_AAAA, 5'd20);   // inner radius forever
      send_point(33'h0_FFFF_FFFF, '0, 33'h0_AAAA_AAAA, 5'd20);   // deep NG
      send_point(33'h0_FFFF_FFFF, '0, 33'h0_5555_5555, 5'd20);
      send_point(33'h0_0000_1000, 33'h0_0000_1000, 33'h0_0000_1000, 5'd20);
      send_point(33'h0_0000_0FFF, 33'h0_FFFF_F000, 33'h0_FFFF_EFFF, 5'd20);
      send_point(C_FULL, C_HALF - 1, C_FULL, 5'd4);
      send_point(33'h0_7FFF_FFFF, 33'h0_7FFF_FFFF, 33'h0_7FFF_FFFF, 5'd2);

      // Sender pauses until the pipeline is empty
      drain_pipeline();

      // Long output hold-off with the sender pushing flat out: the pipe fills
      // and req_ready has to drop
      gaps_on = 1'b0;
      hold_off_pending = 1'b1;
      send_random(150);

      // Bulk random traffic with bursty idling on both sides
      gaps_on = 1'b1;
      send_random(800);
      drain_pipeline();

      // Tail at full rate, no idling anywhere
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      send_random(200);

      // Wait for the last responses, then a little longer for any stray one
      drain_pipeline();
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      $display("Covered %0d requests (%0d with saturated level count), %0d responses checked.",
               board.request_count, board.saturated_count, board.checked_count);
      $display("Input back-pressure seen on %0d cycles; %0d mismatches.",
               backpressure_cycles, board.mismatch_count);
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("PASS sdog_point_to_cell_index");
      end else begin
         $display("FAIL sdog_point_to_cell_index");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #(2_000_000 * CLK_PERIOD / 10);
      $display("Timed out with %0d responses outstanding.", board.pending());
      $display("FAIL sdog_point_to_cell_index");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sdog_pkg.sv
rtl/sdog_point_to_cell_index.sv
rtl/sdog_checker.sv
tb/tb_sdog_point_to_cell_index.sv
